### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// shared constants and types of the register rename table
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int RRT_LOGICAL_REGS = 32;
    localparam int RRT_PHYS_REGS    = 64;

    localparam int RRT_OP_W   = 2;
    localparam int RRT_LREG_W = 5;
    localparam int RRT_PHYS_W = 6;
    localparam int RRT_STAT_W = 2;

    localparam logic [RRT_OP_W-1:0] OP_LOOKUP   = 2'd0;
    localparam logic [RRT_OP_W-1:0] OP_RENAME   = 2'd1;
    localparam logic [RRT_OP_W-1:0] OP_ROLLBACK = 2'd2;

    localparam logic [RRT_STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [RRT_STAT_W-1:0] ST_UNMAPPED  = 2'd1;
    localparam logic [RRT_STAT_W-1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic pop;
        logic push;
    } t_fs_cmd;

endpackage

### sv/register_rename_table.sv
// ----------------------------------------------------------------------------
// register_rename_table
// register alias table with a stack of free physical registers
// ----------------------------------------------------------------------------
// a request is taken at a clock edge with start high and busy low; it carries
// an operation (lookup, rename, rollback), a logical register and a
// speculative flag. the physical register field of each mapping sits in a
// synchronous ram; valid and speculative marks are flip-flops so that
// rollback clears all speculative mappings at once.
// for each request the ram is read at the accepting edge and the entry is
// updated, and the answer (o_phys_reg, o_status) registered, at the end of
// the exec state; o_strobe then shows the answer for exactly one cycle.
// busy is high only in the exec state, so a new request can be taken
// while o_strobe is up, but not while the last one is still updating,
// as the ram's read-then-write of the same entry asks.
// the receiver cannot stall; every answer must be taken in its strobe cycle.
// reset empties the table and refills the free stack in index order at once,
// with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module register_rename_table
    import rrt_pkg::*;
#(
    parameter int LOGICAL_REGS = RRT_LOGICAL_REGS,
    parameter int PHYS_REGS    = RRT_PHYS_REGS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [RRT_OP_W-1:0]   i_operation,
    input  logic [RRT_LREG_W-1:0] i_logical_reg,
    input  logic                  i_speculative,
    output logic                  o_strobe,
    output logic [RRT_PHYS_W-1:0] o_phys_reg,
    output logic [RRT_STAT_W-1:0] o_status
);

    localparam int IW = $clog2(LOGICAL_REGS);
    localparam int PW = $clog2(PHYS_REGS);
    localparam int XW = (IW > RRT_LREG_W) ? IW : RRT_LREG_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [RRT_OP_W-1:0]   r_op;
    logic [IW-1:0]         r_idx;
    logic                  r_in_range;
    logic                  r_spec;
    logic                  r_strobe;
    logic [RRT_PHYS_W-1:0] r_phys;
    logic [RRT_STAT_W-1:0] r_status;
    logic [LOGICAL_REGS-1:0] r_map_valid;
    logic [LOGICAL_REGS-1:0] r_map_spec;

    logic [XW-1:0]         w_lr_x;
    logic [IW-1:0]         w_rd_idx;
    logic                  w_accept;
    logic [PW-1:0]         w_rd_phys;
    logic [PW-1:0]         w_top_val;
    logic                  w_empty;
    logic                  w_do_rename;
    logic                  w_old_valid;
    t_fs_cmd               w_fs_cmd;
    logic [RRT_PHYS_W-1:0] n_phys;
    logic [RRT_STAT_W-1:0] n_status;

    assign w_lr_x   = XW'(i_logical_reg);
    assign w_rd_idx = w_lr_x[IW-1:0];
    assign w_accept = start && (r_state == S_IDLE);

    assign w_old_valid = r_in_range && r_map_valid[r_idx];
    assign w_do_rename = (r_state == S_EXEC) && (r_op == OP_RENAME)
                         && r_in_range && !w_empty;

    assign w_fs_cmd.pop  = w_do_rename;
    assign w_fs_cmd.push = w_old_valid;

    rrt_map_mem #(
        .DEPTH (LOGICAL_REGS),
        .WIDTH (PW)
    ) u_map_mem (
        .i_clk   (i_clk),
        .i_we    (w_do_rename),
        .i_waddr (r_idx),
        .i_wdata (w_top_val),
        .i_raddr (w_rd_idx),
        .o_rdata (w_rd_phys)
    );

    rrt_free_stack #(
        .PHYS_REGS (PHYS_REGS)
    ) u_free_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_fs_cmd),
        .i_push_val (w_rd_phys),
        .o_top_val  (w_top_val),
        .o_empty    (w_empty)
    );

    always_comb begin
        n_phys   = '0;
        n_status = ST_OK;
        unique case (r_op)
            OP_LOOKUP: begin
                if (w_old_valid) begin
                    n_phys = RRT_PHYS_W'(w_rd_phys);
                end else begin
                    n_status = ST_UNMAPPED;
                end
            end
            OP_RENAME: begin
                if (!r_in_range) begin
                    n_status = ST_UNMAPPED;
                end else if (w_empty) begin
                    n_status = ST_EXHAUSTED;
                end else begin
                    n_phys = RRT_PHYS_W'(w_top_val);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_op       <= i_operation;
            r_idx      <= w_rd_idx;
            r_in_range <= (32'(i_logical_reg) < 32'(LOGICAL_REGS));
            r_spec     <= i_speculative;
        end
        if (r_state == S_EXEC) begin
            r_phys   <= n_phys;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= '0;
            r_map_spec  <= '0;
        end else if (r_state == S_EXEC) begin
            if (r_op == OP_ROLLBACK) begin
                r_map_valid <= r_map_valid & ~r_map_spec;
                r_map_spec  <= '0;
            end else if (w_do_rename) begin
                r_map_valid[r_idx] <= 1'b1;
                r_map_spec[r_idx]  <= r_spec;
            end
        end
    end

    assign busy       = (r_state == S_EXEC);
    assign o_strobe   = r_strobe;
    assign o_phys_reg = r_phys;
    assign o_status   = r_status;

    `ASSERT_NEXT(a_accept_busy, w_accept, busy)
    `ASSERT_NEXT(a_exec_strobe, r_state == S_EXEC, o_strobe && !busy)
    `ASSERT_IMPL(a_spec_valid, 1'b1, (r_map_spec & ~r_map_valid) == '0)
    `ASSERT_IMPL(a_err_zero, o_strobe && (o_status != ST_OK), o_phys_reg == '0)

endmodule

### sv/rrt_map_mem.sv
// ----------------------------------------------------------------------------
// rrt_map_mem
// physical register field of the alias table, one write and one read port,
// registered read data
// ----------------------------------------------------------------------------
module rrt_map_mem
    import rrt_pkg::*;
#(
    parameter int DEPTH = RRT_LOGICAL_REGS,
    parameter int WIDTH = $clog2(RRT_PHYS_REGS)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rrt_free_stack.sv
// ----------------------------------------------------------------------------
// rrt_free_stack
// free physical register stack; only the top entry is ever read, entries
// above the top are still in reset order, so the top is held in a register
// ----------------------------------------------------------------------------
module rrt_free_stack
    import rrt_pkg::*;
#(
    parameter int PHYS_REGS = RRT_PHYS_REGS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_fs_cmd                      i_cmd,
    input  logic [$clog2(PHYS_REGS)-1:0] i_push_val,
    output logic [$clog2(PHYS_REGS)-1:0] o_top_val,
    output logic                         o_empty
);

    localparam int PW = $clog2(PHYS_REGS);
    localparam int CW = $clog2(PHYS_REGS + 1);

    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_top_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_top_val <= '0;
        end else if (i_cmd.pop) begin
            if (i_cmd.push) begin
                r_top_val <= i_push_val;
            end else begin
                r_cnt     <= r_cnt + CW'(1);
                r_top_val <= PW'(r_cnt + CW'(1));
            end
        end
    end

    assign o_top_val = r_top_val;
    assign o_empty   = (r_cnt == CW'(PHYS_REGS));

endmodule
